@@ rtl/bts_pkg.sv @@
package bts_pkg;

	// texel store geometry
	localparam int TEXEL_DEPTH = 65536;
	localparam int ADDR_W = $clog2(TEXEL_DEPTH);

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// fixed point constants
	localparam logic [16:0] ONE_FIX = 17'h10000;
	localparam logic [39:0] HALF_LSB = 40'h800000;
	localparam logic [8:0] SIZE_MAX = 9'd256;

	// item passed from front to back
	typedef struct packed {
		logic cmd;
		logic [15:0] waddr;
		logic [23:0] color;
		logic [23:0] px;
		logic [23:0] py;
	} bts_item_t;

	// size register as used: zero reads as one, above 256 as 256
	function automatic logic [8:0] clamp_size(input logic [8:0] s);
		logic [8:0] r;
		r = s;
		if (s == 9'd0)
			r = 9'd1;
		else if (s > SIZE_MAX)
			r = SIZE_MAX;
		return r;
	endfunction

endpackage

@@ rtl/bilinear_texture_sampler_unit.sv @@
// Bilinear texture sampler.
// Input channel (push/full): command 0 writes texel_color at texel_address,
// command 1 samples at coord_u, coord_v (1.16, saturated at 1.0, v flipped).
// Result channel (empty/pop): one beat of red_out, green_out, blue_out in
// 8.8 fixed point per sample beat; write beats give no result.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 sets
// texture_width, 1 sets texture_height; write only while the block is idle.
// Throughput: one beat per cycle unless the receiver stalls. Each texel
// lives in four identical banks, one per neighbour, so the four reads of
// a sample share a single cycle.
// A front stage scales coordinates into a four entry queue; the back
// pipeline forms addresses, reads the banks, weights and blends.
// When the receiver stalls, the two entry result queue fills, the back
// pipeline holds, the middle queue fills and then full rises.
// Reset empties all queues and sets both sizes to 256; texels are
// undefined until written, no clearing pass is made.
module bilinear_texture_sampler_unit import bts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic command,
	input logic [15:0] texel_address,
	input logic [23:0] texel_color,
	input logic [16:0] coord_u,
	input logic [16:0] coord_v,
	output logic empty,
	input logic pop,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [8:0] cfg_data
);

	logic [8:0] width_q, height_q;
	logic [8:0] wid, hgt;
	logic [7:0] wm, hm;
	logic q_push, q_full, q_pop, q_empty;
	bts_item_t q_in, q_out;

	assign cfg_ready = 1'b1;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIZE_MAX;
			height_q <= SIZE_MAX;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sizes as used
	always_comb begin
		wid = clamp_size(width_q);
		hgt = clamp_size(height_q);
		wm = 8'(wid - 9'd1);
		hm = 8'(hgt - 9'd1);
	end

	bts_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .texel_address(texel_address),
		.texel_color(texel_color), .coord_u(coord_u), .coord_v(coord_v),
		.wm(wm), .hm(hm), .q_push(q_push), .q_full(q_full), .q_item(q_in)
	);

	bts_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(q_push), .full(q_full), .wr_item(q_in),
		.rd(q_pop), .empty(q_empty), .rd_item(q_out)
	);

	bts_back u_back (
		.clk(clk), .arst_n(arst_n), .wid(wid), .wm(wm), .hm(hm),
		.q_pop(q_pop), .q_empty(q_empty), .q_item(q_out),
		.empty(empty), .pop(pop),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out)
	);

endmodule

@@ rtl/bts_front.sv @@
module bts_front import bts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic command,
	input logic [15:0] texel_address,
	input logic [23:0] texel_color,
	input logic [16:0] coord_u,
	input logic [16:0] coord_v,
	input logic [7:0] wm,
	input logic [7:0] hm,
	output logic q_push,
	input logic q_full,
	output bts_item_t q_item
);

	logic v_s1;
	bts_item_t item_s1;
	logic adv;
	logic [16:0] u_sat;
	logic [16:0] v_sat;
	logic [16:0] v_flip;

	assign adv = !v_s1 || !q_full;
	assign full = !adv;
	assign q_push = v_s1 && !q_full;
	assign q_item = item_s1;

	// saturate coordinates, flip v
	always_comb begin
		u_sat = (coord_u > ONE_FIX) ? ONE_FIX : coord_u;
		v_sat = (coord_v > ONE_FIX) ? ONE_FIX : coord_v;
		v_flip = ONE_FIX - v_sat;
	end

	// valid of the scaling stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= push;
	end

	// scale by size minus one
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1.cmd <= command;
			item_s1.waddr <= texel_address;
			item_s1.color <= texel_color;
			item_s1.px <= {7'd0, u_sat} * {16'd0, wm};
			item_s1.py <= {7'd0, v_flip} * {16'd0, hm};
		end
	end

endmodule

@@ rtl/bts_queue.sv @@
module bts_queue import bts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr,
	output logic full,
	input bts_item_t wr_item,
	input logic rd,
	output logic empty,
	output bts_item_t rd_item
);

	bts_item_t slots_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_item = slots_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 2'd0;
			rptr_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + 2'd1;
			if (do_rd)
				rptr_q <= rptr_q + 2'd1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 3'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 3'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			slots_q[wptr_q] <= wr_item;
	end

endmodule

@@ rtl/bts_back.sv @@
module bts_back import bts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [8:0] wid,
	input logic [7:0] wm,
	input logic [7:0] hm,
	output logic q_pop,
	input logic q_empty,
	input bts_item_t q_item,
	output logic empty,
	input logic pop,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1 registers
	logic cmd_s1;
	logic [15:0] waddr_s1;
	logic [23:0] color_s1;
	logic [16:0] rowa_s1, rowb_s1;
	logic [7:0] ix_s1, ix1_s1;
	logic [15:0] fx_s1, fy_s1;

	// stage 2 registers
	logic cmd_s2;
	logic wok_s2;
	logic [ADDR_W-1:0] widx_s2;
	logic [23:0] color_s2;
	logic [ADDR_W-1:0] ridx_s2 [4];
	logic [3:0] rok_s2;
	logic [16:0] gx0_s2, gx1_s2, gy0_s2, gy1_s2;

	// stage 3 registers
	logic cmd_s3;
	logic [3:0] rok_s3;
	logic [23:0] rd_s3 [4];
	logic [32:0] w_s3 [4];

	// stage 4 registers
	logic cmd_s4;
	logic [39:0] p_s4 [4][3];

	// combinational helpers
	logic [7:0] ix_c, iy_c, ix1_c, iy1_c;
	logic [16:0] a_c [4];
	logic [39:0] sum_c [3];
	logic res_push;

	// output queue, two entries
	logic [47:0] oq_q [2];
	logic ow_q, or_q;
	logic [1:0] ocnt_q;
	logic do_pop;

	assign adv = (ocnt_q != 2'd2);
	assign q_pop = adv && !q_empty;

	// valid chain, moves as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// integer parts and clamped neighbours
	always_comb begin
		ix_c = q_item.px[23:16];
		iy_c = q_item.py[23:16];
		ix1_c = (({1'b0, ix_c} + 9'd1) > {1'b0, wm}) ? wm : ix_c + 8'd1;
		iy1_c = (({1'b0, iy_c} + 9'd1) > {1'b0, hm}) ? hm : iy_c + 8'd1;
	end

	// stage 1: row offsets
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= q_item.cmd;
			waddr_s1 <= q_item.waddr;
			color_s1 <= q_item.color;
			rowa_s1 <= {9'd0, iy_c} * {8'd0, wid};
			rowb_s1 <= {9'd0, iy1_c} * {8'd0, wid};
			ix_s1 <= ix_c;
			ix1_s1 <= ix1_c;
			fx_s1 <= q_item.px[15:0];
			fy_s1 <= q_item.py[15:0];
		end
	end

	// four neighbour addresses
	always_comb begin
		a_c[0] = rowa_s1 + {9'd0, ix_s1};
		a_c[1] = rowa_s1 + {9'd0, ix1_s1};
		a_c[2] = rowb_s1 + {9'd0, ix_s1};
		a_c[3] = rowb_s1 + {9'd0, ix1_s1};
	end

	// stage 2: addresses and weight terms
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1;
			wok_s2 <= ({16'd0, waddr_s1} < 32'(TEXEL_DEPTH));
			widx_s2 <= ADDR_W'(waddr_s1);
			color_s2 <= color_s1;
			for (int k = 0; k < 4; k++) begin
				ridx_s2[k] <= ADDR_W'(a_c[k]);
				rok_s2[k] <= ({15'd0, a_c[k]} < 32'(TEXEL_DEPTH));
			end
			gx1_s2 <= {1'b0, fx_s1};
			gx0_s2 <= ONE_FIX - {1'b0, fx_s1};
			gy1_s2 <= {1'b0, fy_s1};
			gy0_s2 <= ONE_FIX - {1'b0, fy_s1};
		end
	end

	// stage 3: one bank per neighbour, all written alike
	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [23:0] mem [TEXEL_DEPTH];
		always_ff @(posedge clk) begin
			if (adv) begin
				if (v_s2 && cmd_s2 == CMD_WRITE && wok_s2)
					mem[widx_s2] <= color_s2;
				rd_s3[k] <= mem[ridx_s2[k]];
			end
		end
	end

	// stage 3: weights
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3 <= cmd_s2;
			rok_s3 <= rok_s2;
			w_s3[0] <= {16'd0, gx0_s2} * {16'd0, gy0_s2};
			w_s3[1] <= {16'd0, gx1_s2} * {16'd0, gy0_s2};
			w_s3[2] <= {16'd0, gx0_s2} * {16'd0, gy1_s2};
			w_s3[3] <= {16'd0, gx1_s2} * {16'd0, gy1_s2};
		end
	end

	// stage 4: channel products, missing texels read as zero
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s4 <= cmd_s3;
			for (int k = 0; k < 4; k++) begin
				for (int c = 0; c < 3; c++) begin
					p_s4[k][c] <= rok_s3[k] ?
						{32'd0, rd_s3[k][23-8*c -: 8]} * {7'd0, w_s3[k]} : 40'd0;
				end
			end
		end
	end

	// blend and round half up
	always_comb begin
		for (int c = 0; c < 3; c++)
			sum_c[c] = p_s4[0][c] + p_s4[1][c] + p_s4[2][c] + p_s4[3][c] + HALF_LSB;
	end

	assign res_push = adv && v_s4 && cmd_s4 == CMD_SAMPLE;
	assign empty = (ocnt_q == 2'd0);
	assign do_pop = pop && !empty;
	assign red_out = oq_q[or_q][47:32];
	assign green_out = oq_q[or_q][31:16];
	assign blue_out = oq_q[or_q][15:0];

	// result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q <= 1'b0;
			or_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (res_push)
				ow_q <= !ow_q;
			if (do_pop)
				or_q <= !or_q;
			if (res_push && !do_pop)
				ocnt_q <= ocnt_q + 2'd1;
			else if (do_pop && !res_push)
				ocnt_q <= ocnt_q - 2'd1;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (res_push)
			oq_q[ow_q] <= {sum_c[0][39:24], sum_c[1][39:24], sum_c[2][39:24]};
	end

	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result queue count out of range");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4}))
		else $error("pipeline moved while stalled");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q == 2'd2 |-> !res_push)
		else $error("result written into full queue");

endmodule
